// File: rtl/mdaa_pkg.sv
// ----------------------------------------------------------------------------
// mdaa_pkg
// Shared types and constants for the array address unit: function codes,
// command format passed from the front end to the execute stage, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package mdaa_pkg;

  // Fixed field widths of the item format
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 7;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned DIMS_W  = 5;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned BOUND_W = 16;
  localparam int unsigned EXT_W   = 17;

  // Extent codes above this value are negative
  localparam logic [EXT_W-1:0] EXT_MAX_POS = 17'd65536;

  // Function codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_HEADER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BOUND  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INDEX  = 2'd2;

  // Command queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  typedef enum logic [1:0] {
    CMD_HEADER,
    CMD_BOUND,
    CMD_INDEX
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [ID_W-1:0]      id;
    logic [ADDR_W-1:0]    base;
    logic [SIZE_W-1:0]    size;
    logic [DIMS_W-1:0]    dims;    // already clamped to 1..MAX_DIMS
    logic [POS_W-1:0]     pos;
    logic [BOUND_W-1:0]   lower;
    logic [EXT_W-1:0]     extent;  // upper - lower + 1, 17-bit code
    logic [BOUND_W-1:0]   index;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_ADDR
  } back_state_e;

endpackage

`default_nettype wire

// File: rtl/mdaa_front.sv
// ----------------------------------------------------------------------------
// mdaa_front
// Input front end: accepts items, drops unused codes and out-of-range
// items, clamps the dimension count, computes the extent, and pushes a
// command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mdaa_front #(
  parameter int NUM_ARRAYS = 128,
  parameter int MAX_DIMS   = 16
) (
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [mdaa_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [mdaa_pkg::ID_W-1:0]           array_id_i,
  input  wire logic signed [mdaa_pkg::ADDR_W-1:0]  base_address_i,
  input  wire logic [mdaa_pkg::SIZE_W-1:0]         element_size_i,
  input  wire logic [mdaa_pkg::DIMS_W-1:0]         dim_count_i,
  input  wire logic [mdaa_pkg::POS_W-1:0]          dim_position_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] lower_bound_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] upper_bound_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] index_value_i,
  input  wire logic                                q_full_i,
  output      logic                                q_push_o,
  output      mdaa_pkg::cmd_t                      q_cmd_o
);

  logic                            accept;
  logic                            keep;
  logic                            id_ok;
  logic [mdaa_pkg::DIMS_W-1:0]     dims_clamped;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign id_ok      = 32'(array_id_i) < 32'(NUM_ARRAYS);

  always_comb begin
    if (dim_count_i == '0) begin
      dims_clamped = mdaa_pkg::DIMS_W'(1);
    end else if (32'(dim_count_i) > 32'(MAX_DIMS)) begin
      dims_clamped = mdaa_pkg::DIMS_W'(MAX_DIMS);
    end else begin
      dims_clamped = dim_count_i;
    end
  end

  always_comb begin
    q_cmd_o        = '0;
    q_cmd_o.id     = array_id_i;
    q_cmd_o.base   = base_address_i;
    q_cmd_o.size   = element_size_i;
    q_cmd_o.dims   = dims_clamped;
    q_cmd_o.pos    = dim_position_i;
    q_cmd_o.lower  = lower_bound_i;
    q_cmd_o.extent = {upper_bound_i[mdaa_pkg::BOUND_W-1], upper_bound_i}
                   - {lower_bound_i[mdaa_pkg::BOUND_W-1], lower_bound_i}
                   + mdaa_pkg::EXT_W'(1);
    q_cmd_o.index  = index_value_i;
    keep           = 1'b0;
    case (func_i)
      mdaa_pkg::FUNC_HEADER: begin
        q_cmd_o.kind = mdaa_pkg::CMD_HEADER;
        keep         = 1'b1;
      end
      mdaa_pkg::FUNC_BOUND: begin
        q_cmd_o.kind = mdaa_pkg::CMD_BOUND;
        keep         = 32'(dim_position_i) < 32'(MAX_DIMS);
      end
      mdaa_pkg::FUNC_INDEX: begin
        q_cmd_o.kind = mdaa_pkg::CMD_INDEX;
        keep         = 1'b1;
      end
      default: begin
        q_cmd_o.kind = mdaa_pkg::CMD_HEADER;
        keep         = 1'b0;
      end
    endcase
  end

  assign q_push_o = accept && keep && id_ok;

endmodule

`default_nettype wire

// File: rtl/mdaa_queue.sv
// ----------------------------------------------------------------------------
// mdaa_queue
// Two-entry command queue between the front end and the execute stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mdaa_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mdaa_pkg::cmd_t push_cmd_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           valid_o,
  output      mdaa_pkg::cmd_t head_o
);

  mdaa_pkg::cmd_t                entry_q [mdaa_pkg::QUEUE_DEPTH];
  logic [mdaa_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [mdaa_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [mdaa_pkg::QCNT_W-1:0]   count_q, count_d;

  assign full_o  = count_q == mdaa_pkg::QCNT_W'(mdaa_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + mdaa_pkg::QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + mdaa_pkg::QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + mdaa_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - mdaa_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mdaa_back.sv
// ----------------------------------------------------------------------------
// mdaa_back
// Execute stage: holds the descriptor tables, writes headers and bounds,
// runs the Horner multiply-accumulate per index and forms the address.
// ----------------------------------------------------------------------------
`default_nettype none

module mdaa_back #(
  parameter int NUM_ARRAYS = 128,
  parameter int MAX_DIMS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                q_valid_i,
  input  wire mdaa_pkg::cmd_t                      q_cmd_i,
  output      logic                                q_pop_o,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [mdaa_pkg::ADDR_W-1:0]  address_o,
  output      logic [mdaa_pkg::ID_W-1:0]           result_array_id_o
);

  localparam int AW    = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SLOTS = NUM_ARRAYS * (1 << DW);

  localparam int A_W = mdaa_pkg::ADDR_W;

  // Descriptor tables
  logic [A_W-1:0]                  base_mem   [NUM_ARRAYS];
  logic [mdaa_pkg::SIZE_W-1:0]     size_mem   [NUM_ARRAYS];
  logic [mdaa_pkg::DIMS_W-1:0]     dims_mem   [NUM_ARRAYS];
  logic [mdaa_pkg::BOUND_W-1:0]    lower_mem  [SLOTS];
  logic [mdaa_pkg::EXT_W-1:0]      extent_mem [SLOTS];

  logic [A_W-1:0]                  base_rd_q;
  logic [mdaa_pkg::SIZE_W-1:0]     size_rd_q;
  logic [mdaa_pkg::DIMS_W-1:0]     dims_rd_q;
  logic [mdaa_pkg::BOUND_W-1:0]    lower_rd_q;
  logic [mdaa_pkg::EXT_W-1:0]      extent_rd_q;

  mdaa_pkg::back_state_e           state_q, state_d;

  logic [A_W-1:0]                  acc_q;
  logic [DW-1:0]                   pos_q;
  logic [mdaa_pkg::BOUND_W-1:0]    idx_q;
  logic [mdaa_pkg::ID_W-1:0]       id_q;
  logic                            out_valid_q;
  logic [A_W-1:0]                  addr_q;
  logic [mdaa_pkg::ID_W-1:0]       rid_q;

  logic                            hdr_we;
  logic                            bnd_we;
  logic                            idx_start;
  logic                            mac_en;
  logic                            out_load;
  logic                            last;

  logic [AW-1:0]                   tab_addr;
  logic [AW+DW-1:0]                slot_addr;
  logic [A_W-1:0]                  ext_val;
  logic [A_W-1:0]                  diff;
  logic [A_W-1:0]                  acc_new;
  logic [A_W-1:0]                  addr_new;

  assign tab_addr  = AW'(q_cmd_i.id);
  assign slot_addr = (q_cmd_i.kind == mdaa_pkg::CMD_BOUND)
                   ? {tab_addr, q_cmd_i.pos[DW-1:0]}
                   : {tab_addr, pos_q};

  // Read data is captured when an index starts and held through the address step
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      base_mem[tab_addr] <= q_cmd_i.base;
      size_mem[tab_addr] <= q_cmd_i.size;
      dims_mem[tab_addr] <= q_cmd_i.dims;
    end
    if (idx_start) begin
      base_rd_q <= base_mem[tab_addr];
      size_rd_q <= size_mem[tab_addr];
      dims_rd_q <= dims_mem[tab_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      lower_mem[slot_addr]  <= q_cmd_i.lower;
      extent_mem[slot_addr] <= q_cmd_i.extent;
    end
    if (idx_start) begin
      lower_rd_q  <= lower_mem[slot_addr];
      extent_rd_q <= extent_mem[slot_addr];
    end
  end

  // Extent code 65537..131071 is a negative extent
  assign ext_val = (extent_rd_q > mdaa_pkg::EXT_MAX_POS)
                 ? {{(A_W - mdaa_pkg::EXT_W){1'b1}}, extent_rd_q}
                 : {{(A_W - mdaa_pkg::EXT_W){1'b0}}, extent_rd_q};

  assign diff     = A_W'(signed'(idx_q)) - A_W'(signed'(lower_rd_q));
  assign acc_new  = A_W'(acc_q * ext_val) + diff;
  assign last     = (mdaa_pkg::DIMS_W'(pos_q) + mdaa_pkg::DIMS_W'(1)) >= dims_rd_q;
  assign addr_new = base_rd_q + A_W'(acc_q * {{(A_W - mdaa_pkg::SIZE_W){1'b0}}, size_rd_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdaa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    hdr_we    = 1'b0;
    bnd_we    = 1'b0;
    idx_start = 1'b0;
    mac_en    = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      mdaa_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.kind)
            mdaa_pkg::CMD_HEADER: hdr_we = 1'b1;
            mdaa_pkg::CMD_BOUND:  bnd_we = 1'b1;
            mdaa_pkg::CMD_INDEX: begin
              idx_start = 1'b1;
              state_d   = mdaa_pkg::ST_MAC;
            end
            default: ;
          endcase
        end
      end
      mdaa_pkg::ST_MAC: begin
        mac_en  = 1'b1;
        state_d = last ? mdaa_pkg::ST_ADDR : mdaa_pkg::ST_IDLE;
      end
      mdaa_pkg::ST_ADDR: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = mdaa_pkg::ST_IDLE;
        end
      end
      default: state_d = mdaa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (hdr_we) begin
        acc_q <= '0;
        pos_q <= '0;
      end
      if (mac_en) begin
        acc_q <= acc_new;
        pos_q <= last ? '0 : pos_q + DW'(1);
      end
      if (out_load) begin
        acc_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (idx_start) begin
      idx_q <= q_cmd_i.index;
      id_q  <= q_cmd_i.id;
    end
    if (out_load) begin
      addr_q <= addr_new;
      rid_q  <= id_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign address_o         = addr_q;
  assign result_array_id_o = rid_q;

endmodule

`default_nettype wire

// File: rtl/multidim_array_address.sv
// ----------------------------------------------------------------------------
// multidim_array_address
// Row-major array address unit with a descriptor table per array number.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): header items set base, element
// size and dimension count; bound items set one dimension's bounds; index
// items stream subscripts, first dimension first. Unused codes and array
// numbers beyond NUM_ARRAYS are taken and dropped.
// Output channel (out_valid_o / out_stall_i): one address per completed
// reference, base + offset * element_size, wrapping at 32 bits.
// A front end queues commands in a two-entry queue; the execute stage
// takes one command at a time. Header and bound items are written to the
// tables there. An index item is a registered table read, then the
// multiply-accumulate on the running offset. The last index of a reference
// adds an address step: the element-size multiply into the output register,
// which waits while the receiver stalls a held result.
// Reset clears the running offset and position and the queue; the tables
// hold nothing until written. When the receiver stalls, the result stays
// in the output register, the next result waits in the execute stage and
// input is stalled once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module multidim_array_address #(
  parameter int NUM_ARRAYS = 128,
  parameter int MAX_DIMS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [mdaa_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [mdaa_pkg::ID_W-1:0]           array_id_i,
  input  wire logic signed [mdaa_pkg::ADDR_W-1:0]  base_address_i,
  input  wire logic [mdaa_pkg::SIZE_W-1:0]         element_size_i,
  input  wire logic [mdaa_pkg::DIMS_W-1:0]         dim_count_i,
  input  wire logic [mdaa_pkg::POS_W-1:0]          dim_position_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] lower_bound_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] upper_bound_i,
  input  wire logic signed [mdaa_pkg::BOUND_W-1:0] index_value_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [mdaa_pkg::ADDR_W-1:0]  address_o,
  output      logic [mdaa_pkg::ID_W-1:0]           result_array_id_o
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  mdaa_pkg::cmd_t push_cmd;
  mdaa_pkg::cmd_t head_cmd;

  mdaa_front #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .array_id_i     (array_id_i),
    .base_address_i (base_address_i),
    .element_size_i (element_size_i),
    .dim_count_i    (dim_count_i),
    .dim_position_i (dim_position_i),
    .lower_bound_i  (lower_bound_i),
    .upper_bound_i  (upper_bound_i),
    .index_value_i  (index_value_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  mdaa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  mdaa_back #(
    .NUM_ARRAYS (NUM_ARRAYS),
    .MAX_DIMS   (MAX_DIMS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (q_valid),
    .q_cmd_i           (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .address_o         (address_o),
    .result_array_id_o (result_array_id_o)
  );

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the row-major array address unit. Header, bound
// and index transfers are queued up front, handed to the block with random
// gaps and checked against a cycle-free descriptor-table model. Addresses are
// compared field by field in order, with random and long receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ARR  = 128;
  localparam int N_DIM  = 16;
  localparam int N_SLOT = N_ARR * N_DIM;
  localparam int ITEM_TARGET = 550;  // directed part plus random part
  localparam logic [mdaa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [mdaa_pkg::FUNC_W-1:0]  func;
    logic [mdaa_pkg::ID_W-1:0]    id;
    logic [mdaa_pkg::ADDR_W-1:0]  base;
    logic [mdaa_pkg::SIZE_W-1:0]  elem_size;
    logic [mdaa_pkg::DIMS_W-1:0]  dims;
    logic [mdaa_pkg::POS_W-1:0]   pos;
    logic [mdaa_pkg::BOUND_W-1:0] lower;
    logic [mdaa_pkg::BOUND_W-1:0] upper;
    logic [mdaa_pkg::BOUND_W-1:0] index;
    bit                           wait_drain;
  } array_req_t;

  typedef struct {
    logic [mdaa_pkg::ADDR_W-1:0] addr;
    logic [mdaa_pkg::ID_W-1:0]   id;
  } elem_addr_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [mdaa_pkg::FUNC_W-1:0]  func = '0;
  logic [mdaa_pkg::ID_W-1:0]    array_id = '0;
  logic [mdaa_pkg::ADDR_W-1:0]  base_address = '0;
  logic [mdaa_pkg::SIZE_W-1:0]  element_size = '0;
  logic [mdaa_pkg::DIMS_W-1:0]  dim_count = '0;
  logic [mdaa_pkg::POS_W-1:0]   dim_position = '0;
  logic [mdaa_pkg::BOUND_W-1:0] lower_bound = '0;
  logic [mdaa_pkg::BOUND_W-1:0] upper_bound = '0;
  logic [mdaa_pkg::BOUND_W-1:0] index_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [mdaa_pkg::ADDR_W-1:0]  address;
  logic [mdaa_pkg::ID_W-1:0]    result_array_id;

  multidim_array_address dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .func_i            (func),
    .array_id_i        (array_id),
    .base_address_i    (base_address),
    .element_size_i    (element_size),
    .dim_count_i       (dim_count),
    .dim_position_i    (dim_position),
    .lower_bound_i     (lower_bound),
    .upper_bound_i     (upper_bound),
    .index_value_i     (index_value),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .address_o         (address),
    .result_array_id_o (result_array_id)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  array_req_t req_q[$];
  elem_addr_t addr_q[$];
  int n_errors = 0;
  int n_addrs = 0;

  // ---------------- descriptor model, advanced on each accepted transfer
  logic [mdaa_pkg::ADDR_W-1:0]  base_mem   [N_ARR];
  logic [mdaa_pkg::SIZE_W-1:0]  size_mem   [N_ARR];
  int                           dims_mem   [N_ARR];
  logic [mdaa_pkg::BOUND_W-1:0] lower_mem  [N_SLOT];
  logic [mdaa_pkg::EXT_W-1:0]   extent_mem [N_SLOT];
  logic [mdaa_pkg::ADDR_W-1:0]  run_offset = '0;
  logic [mdaa_pkg::POS_W-1:0]   run_pos = '0;

  function automatic int clamp_dims(logic [mdaa_pkg::DIMS_W-1:0] d);
    if (d == 0) return 1;
    if (d > N_DIM) return N_DIM;
    return int'(d);
  endfunction

  function automatic logic [mdaa_pkg::ADDR_W-1:0] sext16(logic [mdaa_pkg::BOUND_W-1:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic predict_addr(input array_req_t r);
    logic [mdaa_pkg::ADDR_W-1:0] diff;
    logic [mdaa_pkg::ADDR_W-1:0] ext;
    logic [mdaa_pkg::ADDR_W-1:0] acc;
    logic [mdaa_pkg::ID_W+mdaa_pkg::POS_W-1:0] slot;
    elem_addr_t e;
    case (r.func)
      mdaa_pkg::FUNC_HEADER: begin
        base_mem[r.id] = r.base;
        size_mem[r.id] = r.elem_size;
        dims_mem[r.id] = clamp_dims(r.dims);
        run_offset = '0;
        run_pos = '0;
      end
      mdaa_pkg::FUNC_BOUND: begin
        slot = {r.id, r.pos};
        lower_mem[slot] = r.lower;
        ext = sext16(r.upper) - sext16(r.lower) + 32'd1;
        extent_mem[slot] = ext[mdaa_pkg::EXT_W-1:0];
      end
      mdaa_pkg::FUNC_INDEX: begin
        slot = {r.id, run_pos};
        diff = sext16(r.index) - sext16(lower_mem[slot]);
        // 17-bit extent codes above +65536 are negative
        ext = (extent_mem[slot] > mdaa_pkg::EXT_MAX_POS) ? {15'h7fff, extent_mem[slot]}
                                                         : {15'h0, extent_mem[slot]};
        acc = run_offset * ext + diff;
        if (int'(run_pos) + 1 >= dims_mem[r.id]) begin
          e.addr = base_mem[r.id] + acc * {16'h0, size_mem[r.id]};
          e.id = r.id;
          addr_q.push_back(e);
          run_offset = '0;
          run_pos = '0;
        end else begin
          run_offset = acc;
          run_pos = run_pos + 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus generation; tracks which entries are written
  bit hdr_done [N_ARR];
  bit bnd_done [N_SLOT];
  int gen_dims [N_ARR];
  int gen_lower [N_SLOT];
  int gen_pos = 0;
  int live_ids[$];
  int n_queued = 0;
  bit drain_next = 1'b0;

  function automatic array_req_t rand_req(logic [mdaa_pkg::FUNC_W-1:0] f, int id);
    array_req_t r;
    r.func = f;
    r.id = mdaa_pkg::ID_W'(id);
    r.base = $urandom;
    r.elem_size = mdaa_pkg::SIZE_W'($urandom);
    r.dims = mdaa_pkg::DIMS_W'($urandom);
    r.pos = mdaa_pkg::POS_W'($urandom);
    r.lower = mdaa_pkg::BOUND_W'($urandom);
    r.upper = mdaa_pkg::BOUND_W'($urandom);
    r.index = mdaa_pkg::BOUND_W'($urandom);
    r.wait_drain = 1'b0;
    return r;
  endfunction

  function automatic logic [mdaa_pkg::SIZE_W-1:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return mdaa_pkg::SIZE_W'($urandom_range(1, 16));
    if (r < 90) return '0;
    return mdaa_pkg::SIZE_W'($urandom);
  endfunction

  task automatic queue_req(input array_req_t r);
    r.wait_drain = drain_next;
    drain_next = 1'b0;
    req_q.push_back(r);
    n_queued++;
    case (r.func)
      mdaa_pkg::FUNC_HEADER: begin
        if (!hdr_done[r.id]) live_ids.push_back(int'(r.id));
        hdr_done[r.id] = 1'b1;
        gen_dims[r.id] = clamp_dims(r.dims);
        gen_pos = 0;
      end
      mdaa_pkg::FUNC_BOUND: begin
        bnd_done[{r.id, r.pos}] = 1'b1;
        gen_lower[{r.id, r.pos}] = int'($signed(r.lower));
      end
      mdaa_pkg::FUNC_INDEX: begin
        if (gen_pos + 1 >= gen_dims[r.id]) gen_pos = 0;
        else gen_pos++;
      end
      default: ;
    endcase
  endtask

  task automatic send_header(int id, logic [mdaa_pkg::ADDR_W-1:0] base,
                             logic [mdaa_pkg::SIZE_W-1:0] sz,
                             logic [mdaa_pkg::DIMS_W-1:0] dims);
    array_req_t r;
    r = rand_req(mdaa_pkg::FUNC_HEADER, id);
    r.base = base;
    r.elem_size = sz;
    r.dims = dims;
    queue_req(r);
  endtask

  task automatic send_bound(int id, int pos, int lo, int hi);
    array_req_t r;
    r = rand_req(mdaa_pkg::FUNC_BOUND, id);
    r.pos = mdaa_pkg::POS_W'(pos);
    r.lower = mdaa_pkg::BOUND_W'(lo);
    r.upper = mdaa_pkg::BOUND_W'(hi);
    queue_req(r);
  endtask

  task automatic send_rand_bound(int id, int pos);
    int lo;
    int hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, 65535) - 32768;
        hi = lo;
      end
      1: begin
        lo = $urandom_range(0, 65535) - 32768;
        hi = $urandom_range(0, 65535) - 32768;
      end
      2: begin
        lo = -32768;
        hi = 32767;
      end
      default: begin
        lo = $urandom_range(0, 40) - 20;
        hi = lo + $urandom_range(0, 30) - 1;  // hi = lo - 1 gives an empty dimension
      end
    endcase
    send_bound(id, pos, lo, hi);
  endtask

  // Writes whatever the index transfer will read before queuing it
  task automatic send_index(int id, bit auto_val, int val);
    array_req_t r;
    if (!hdr_done[id]) begin
      send_header(id, $urandom, rand_size(), mdaa_pkg::DIMS_W'($urandom_range(1, 3)));
    end
    if (!bnd_done[id * N_DIM + gen_pos]) send_rand_bound(id, gen_pos);
    if (auto_val) begin
      if ($urandom_range(0, 99) < 35) val = $urandom_range(0, 65535) - 32768;
      else val = gen_lower[id * N_DIM + gen_pos] + $urandom_range(0, 12);
    end
    r = rand_req(mdaa_pkg::FUNC_INDEX, id);
    r.index = mdaa_pkg::BOUND_W'(val);
    queue_req(r);
  endtask

  task automatic define_array(int id);
    int d;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) d = $urandom_range(1, 3);
    else if (r < 80) d = $urandom_range(4, 16);
    else if (r < 90) d = 0;
    else d = $urandom_range(17, 31);
    send_header(id, $urandom, rand_size(), mdaa_pkg::DIMS_W'(d));
    for (int p = 0; p < clamp_dims(mdaa_pkg::DIMS_W'(d)); p++) send_rand_bound(id, p);
  endtask

  task automatic run_reference(int id);
    do send_index(id, 1'b1, 0); while (gen_pos != 0);
  endtask

  function automatic int pick_live();
    return live_ids[$urandom_range(0, live_ids.size() - 1)];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------- input driver
  array_req_t cur_req;
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_addr(cur_req);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 && !(req_q[0].wait_drain && addr_q.size() != 0)) begin
          cur_req = req_q.pop_front();
          func <= cur_req.func;
          array_id <= cur_req.id;
          base_address <= cur_req.base;
          element_size <= cur_req.elem_size;
          dim_count <= cur_req.dims;
          dim_position <= cur_req.pos;
          lower_bound <= cur_req.lower;
          upper_bound <= cur_req.upper;
          index_value <= cur_req.index;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
            gap_left = 0;
          end else begin
            gap_left = ($urandom_range(0, 99) < 55) ? 0 : idle_len();
            if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(30, 80);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver: random stalls plus one long hold-off
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_left = 0;
  bit rx_stall = 1'b0;

  always @(posedge clk_i) begin
    if (!hold_done && n_addrs >= 30) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    bit nxt;
    nxt = rx_stall;
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      nxt = ($urandom_range(0, 99) < 35);
      if (nxt) rx_left <= idle_len();
      else rx_left <= ($urandom_range(0, 99) < 8) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
    end
    rx_stall <= nxt;
    out_stall <= nxt || (hold_left != 0);
  end

  // ---------------- output monitor
  always @(posedge clk_i) begin
    elem_addr_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (addr_q.size() == 0) begin
        $display("%0t: address %h for array %0d with none expected",
                 $time, address, result_array_id);
        n_errors++;
      end else begin
        want = addr_q.pop_front();
        if (address !== want.addr) begin
          $display("%0t: address mismatch: expected %h, actual %h", $time, want.addr, address);
          n_errors++;
        end
        if (result_array_id !== want.id) begin
          $display("%0t: array id mismatch: expected %0d, actual %0d",
                   $time, want.id, result_array_id);
          n_errors++;
        end
      end
      n_addrs <= n_addrs + 1;
    end
  end

  initial begin
    int sel;

    // directed: bound extremes, zero size, clamped counts, unused code,
    // header mid-reference and a reference that switches arrays
    send_header(0, 32'h7fff_ffff, 16'hffff, 5'd1);
    send_bound(0, 0, -32768, 32767);
    send_index(0, 1'b0, 32767);
    send_index(0, 1'b0, -32768);
    send_header(1, 32'h8000_0000, 16'h0, 5'd0);
    send_bound(1, 0, 32767, -32768);
    send_index(1, 1'b0, -32768);
    send_header(2, 32'h0000_1000, 16'd3, 5'd2);
    send_bound(2, 0, 5, 4);
    send_bound(2, 1, -10, 10);
    send_index(2, 1'b0, 7);
    queue_req(rand_req(FUNC_UNUSED, 2));
    send_index(2, 1'b0, -3);
    send_index(2, 1'b0, 100);
    send_header(3, 32'hffff_fff0, 16'd1, 5'd2);
    send_bound(3, 0, 0, 9);
    send_bound(3, 1, 0, 9);
    send_bound(0, 1, -1, 1);
    send_index(3, 1'b0, 4);
    send_index(0, 1'b0, 1);
    send_header(127, $urandom, 16'd8, 5'd31);
    send_bound(127, 0, -32768, -32768);
    send_index(127, 1'b0, -32768);

    drain_next = 1'b1;
    while (n_queued < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (live_ids.size() == 0 || sel < 12) begin
        define_array($urandom_range(0, N_ARR - 1));
      end else if (sel < 72) begin
        run_reference(pick_live());
      end else if (sel < 80) begin
        // partial reference, possibly across arrays
        repeat ($urandom_range(1, 3)) send_index(pick_live(), 1'b1, 0);
      end else if (sel < 86) begin
        queue_req(rand_req(FUNC_UNUSED, $urandom_range(0, N_ARR - 1)));
      end else if (sel < 93) begin
        send_rand_bound(pick_live(), $urandom_range(0, N_DIM - 1));
      end else begin
        send_header(pick_live(), $urandom, rand_size(), mdaa_pkg::DIMS_W'($urandom));
      end
      if ($urandom_range(0, 199) == 0) drain_next = 1'b1;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (req_q.size() != 0 || in_valid || addr_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d addresses outstanding", $time, addr_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
